// ----- hw/rtl/arw_pkg.sv -----
package arw_pkg;

   localparam int SEQ_W      = 32;
   localparam int WIN_W      = 6;
   localparam int VERDICT_W  = 3;
   localparam int BYTE_W     = 8;
   localparam int BLK_W      = SEQ_W - 3;

   localparam logic [WIN_W-1:0]  WIN_RESET = 6'd32;
   localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;

   typedef enum logic [VERDICT_W-1:0] {
      V_IN_ORDER    = 3'd0,
      V_LATE_FILLED = 3'd1,
      V_GAP         = 3'd2,
      V_JUMP        = 3'd3,
      V_TOO_OLD     = 3'd4,
      V_REPLAY      = 3'd5
   } arw_verdict_type;

endpackage

// ----- hw/rtl/arw_req_if.sv -----
interface arw_req_if;
   import arw_pkg::*;

   logic             valid;
   logic             ready;
   logic [SEQ_W-1:0] seq_number;

   modport source (output valid, output seq_number, input ready);
   modport sink   (input valid, input seq_number, output ready);
endinterface

// ----- hw/rtl/arw_rsp_if.sv -----
interface arw_rsp_if;
   import arw_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 accepted;
   logic [VERDICT_W-1:0] verdict;
   logic [SEQ_W-1:0]     lost_count;
   logic [SEQ_W-1:0]     received_total;

   modport source (output valid, output accepted, output verdict, output lost_count,
                   output received_total, input ready);
   modport sink   (input valid, input accepted, input verdict, input lost_count,
                   input received_total, output ready);
endinterface

// ----- hw/rtl/arw_csr_if.sv -----
interface arw_csr_if;
   import arw_pkg::*;

   logic             valid;
   logic             ready;
   logic [WIN_W-1:0] window_bytes;

   modport source (output valid, output window_bytes, input ready);
   modport sink   (input valid, input window_bytes, output ready);
endinterface

// ----- hw/rtl/anti_replay_window_top.sv -----
// Anti-replay filter: one transaction per sequence number, one response each. The late
// bitmap sits in a single-port-write / single-port-read RAM of MAX_WINDOW_BYTES bytes with
// per-byte valid flops, so reset is immediate and there is no clearing pass. Per item: the
// transaction is taken, then the byte index (seq/8 mod window) is found by a shared
// remainder unit at 4 bits per cycle, overlapped with classification. After that the RAM
// work: in-order and late packets do one read-modify-write, a forward gap walks back one
// byte per cycle, a far jump rewrites the window at one byte per cycle. The FINISH state
// then loads the response register, waiting while the last response is still pending. A
// zero window or a too-old packet skips the remainder and the RAM work. A new transaction
// is taken while the last response still waits on rsp_ch. window_bytes above
// MAX_WINDOW_BYTES saturates; write it only while idle.
module anti_replay_window_top #(
   parameter int MAX_WINDOW_BYTES = 32
) (
   input  logic          clock,
   input  logic          reset,
   arw_req_if.sink       req_ch,
   arw_rsp_if.source     rsp_ch,
   arw_csr_if.sink       csr_ch
);
   import arw_pkg::*;

   localparam int AW        = (MAX_WINDOW_BYTES > 1) ? $clog2(MAX_WINDOW_BYTES) : 1;
   localparam int MOD_STEPS = 8;
   localparam int MCNT_W    = $clog2(MOD_STEPS);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CALC   = 6'b000010,
      ST_MOD    = 6'b000100,
      ST_FILL   = 6'b001000,
      ST_WALK   = 6'b010000,
      ST_FINISH = 6'b100000
   } arw_state_type;

   arw_state_type         state_ff, state_in;
   logic [WIN_W-1:0]      window_bytes_ff, window_bytes_in;
   logic [SEQ_W-1:0]      exp_ff, exp_in;
   logic [SEQ_W-1:0]      cnt_ff, cnt_in;

   logic [SEQ_W-1:0]      seq_ff, seq_in;
   logic [SEQ_W-1:0]      seq_inc_ff, seq_inc_in;
   logic [SEQ_W-1:0]      diff_ff, diff_in;
   logic [SEQ_W-1:0]      exp_plus_ff, exp_plus_in;
   logic [SEQ_W-1:0]      exp_minus_ff, exp_minus_in;
   logic                  ge_ff, ge_in;
   logic [WIN_W-1:0]      w_ff, w_in;
   arw_verdict_type       verdict_ff, verdict_in;
   logic                  accept_ff, accept_in;

   // remainder unit
   logic [SEQ_W-1:0]      div_ff, div_in;
   logic [WIN_W-1:0]      rem_ff, rem_in;
   logic [MCNT_W-1:0]     mcnt_ff, mcnt_in;
   logic [WIN_W-1:0]      rem_step;

   // walk issue side
   logic                  cur_act_ff, cur_act_in;
   logic [WIN_W-1:0]      cur_idx_ff, cur_idx_in;
   logic [BLK_W-1:0]      cur_blk_ff, cur_blk_in;
   logic [BLK_W-1:0]      stop_blk_ff, stop_blk_in;
   logic [WIN_W-1:0]      fill_idx_ff, fill_idx_in;

   // walk consume side
   logic                  p1_vld_ff, p1_vld_in;
   logic [WIN_W-1:0]      p1_idx_ff, p1_idx_in;
   logic [BYTE_W-1:0]     p1_set_ff, p1_set_in;
   logic [BYTE_W-1:0]     p1_clr_ff, p1_clr_in;
   logic                  p1_last_ff, p1_last_in;

   // write forwarding
   logic                  fwd_vld_ff, fwd_vld_in;
   logic [WIN_W-1:0]      fwd_idx_ff, fwd_idx_in;
   logic [BYTE_W-1:0]     fwd_data_ff, fwd_data_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_accepted_ff, rsp_accepted_in;
   logic [VERDICT_W-1:0]  rsp_verdict_ff, rsp_verdict_in;
   logic [SEQ_W-1:0]      rsp_lost_ff, rsp_lost_in;
   logic [SEQ_W-1:0]      rsp_total_ff, rsp_total_in;

   // memory
   logic [BYTE_W-1:0]         late_mem [MAX_WINDOW_BYTES];
   logic [MAX_WINDOW_BYTES-1:0] late_vld_ff;
   logic [BYTE_W-1:0]         mem_rd_data_ff;
   logic                      mem_rd_valid_ff;
   logic                      rd_en, wr_en;
   logic [WIN_W-1:0]          rd_idx, wr_idx;
   logic [BYTE_W-1:0]         wr_data;

   logic [WIN_W-1:0]      w_eff;
   logic [SEQ_W-1:0]      span_eff, span_ff;
   logic [BYTE_W-1:0]     seq_bit;
   logic [BYTE_W-1:0]     lo_mask, hi_mask, base, new_byte;
   logic                  is_top, is_bot;
   logic [SEQ_W-1:0]      exp_next, cnt_next;

   assign w_eff    = ({{(SEQ_W-WIN_W){1'b0}}, window_bytes_ff} > SEQ_W'(MAX_WINDOW_BYTES))
                   ? WIN_W'(MAX_WINDOW_BYTES) : window_bytes_ff;
   assign span_eff = {{(SEQ_W-WIN_W-3){1'b0}}, w_eff, 3'b000};
   assign span_ff  = {{(SEQ_W-WIN_W-3){1'b0}}, w_ff, 3'b000};
   assign seq_bit  = BYTE_W'(1) << seq_ff[2:0];

   assign req_ch.ready           = (state_ff == ST_IDLE);
   assign csr_ch.ready           = 1'b1;
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.accepted        = rsp_accepted_ff;
   assign rsp_ch.verdict         = rsp_verdict_ff;
   assign rsp_ch.lost_count      = rsp_lost_ff;
   assign rsp_ch.received_total  = rsp_total_ff;

   // four restoring steps of (seq/8) mod w per cycle, remainder stays below w
   always_comb begin
      logic [WIN_W:0]   t;
      logic [WIN_W-1:0] r;
      r = rem_ff;
      for (int k = 0; k < 4; k++) begin
         t = {r, div_ff[SEQ_W-1-k]};
         if (t >= {1'b0, w_ff}) begin
            t = t - {1'b0, w_ff};
         end
         r = t[WIN_W-1:0];
      end
      rem_step = r;
   end

   // masks for the block being issued in a walk
   always_comb begin
      is_top  = (cur_blk_ff == seq_ff[SEQ_W-1:3]);
      is_bot  = (cur_blk_ff == exp_ff[SEQ_W-1:3]);
      lo_mask = is_bot ? (BYTE_ONES << exp_ff[2:0]) : BYTE_ONES;
      hi_mask = is_top ? (seq_bit - BYTE_W'(1)) : BYTE_ONES;
   end

   always_comb begin
      base = (fwd_vld_ff && (fwd_idx_ff == p1_idx_ff)) ? fwd_data_ff
           : (mem_rd_valid_ff ? mem_rd_data_ff : '0);
      new_byte = (base | p1_set_ff) & ~p1_clr_ff;
      exp_next = ge_ff ? seq_inc_ff : exp_ff;
      cnt_next = (exp_next == '0) ? '0 : cnt_ff + SEQ_W'(1);
   end

   always_comb begin
      state_in        = state_ff;
      window_bytes_in = window_bytes_ff;
      exp_in          = exp_ff;
      cnt_in          = cnt_ff;
      seq_in          = seq_ff;
      seq_inc_in      = seq_inc_ff;
      diff_in         = diff_ff;
      exp_plus_in     = exp_plus_ff;
      exp_minus_in    = exp_minus_ff;
      ge_in           = ge_ff;
      w_in            = w_ff;
      verdict_in      = verdict_ff;
      accept_in       = accept_ff;
      div_in          = div_ff;
      rem_in          = rem_ff;
      mcnt_in         = mcnt_ff;
      cur_act_in      = cur_act_ff;
      cur_idx_in      = cur_idx_ff;
      cur_blk_in      = cur_blk_ff;
      stop_blk_in     = stop_blk_ff;
      fill_idx_in     = fill_idx_ff;
      p1_vld_in       = 1'b0;
      p1_idx_in       = p1_idx_ff;
      p1_set_in       = p1_set_ff;
      p1_clr_in       = p1_clr_ff;
      p1_last_in      = p1_last_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_verdict_in  = rsp_verdict_ff;
      rsp_lost_in     = rsp_lost_ff;
      rsp_total_in    = rsp_total_ff;
      rd_en           = 1'b0;
      rd_idx          = cur_idx_ff;
      wr_en           = 1'b0;
      wr_idx          = p1_idx_ff;
      wr_data         = new_byte;

      if (csr_ch.valid) begin
         window_bytes_in = csr_ch.window_bytes;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               seq_in       = req_ch.seq_number;
               seq_inc_in   = req_ch.seq_number + SEQ_W'(1);
               diff_in      = req_ch.seq_number - exp_ff;
               exp_plus_in  = exp_ff + span_eff;
               exp_minus_in = exp_ff - span_eff;
               ge_in        = (req_ch.seq_number >= exp_ff);
               w_in         = w_eff;
               div_in       = {3'b000, req_ch.seq_number[SEQ_W-1:3]};
               rem_in       = '0;
               mcnt_in      = '0;
               state_in     = ST_CALC;
            end
         end
         ST_CALC: begin
            div_in    = div_ff << 4;
            rem_in    = rem_step;
            mcnt_in   = mcnt_ff + MCNT_W'(1);
            accept_in = 1'b1;
            state_in  = ST_MOD;
            if (w_ff == '0) begin
               verdict_in = V_IN_ORDER;
               state_in   = ST_FINISH;
            end else if (diff_ff == '0) begin
               verdict_in = V_IN_ORDER;
            end else if (seq_ff >= exp_plus_ff) begin
               verdict_in = V_JUMP;
            end else if (!ge_ff) begin
               if (exp_ff >= span_ff && seq_ff < exp_minus_ff) begin
                  verdict_in = V_TOO_OLD;
                  accept_in  = 1'b0;
                  state_in   = ST_FINISH;
               end else begin
                  verdict_in = V_LATE_FILLED;
               end
            end else begin
               verdict_in = V_GAP;
            end
         end
         ST_MOD: begin
            div_in  = div_ff << 4;
            rem_in  = rem_step;
            mcnt_in = mcnt_ff + MCNT_W'(1);
            if (mcnt_ff == MCNT_W'(MOD_STEPS - 1)) begin
               cur_idx_in  = rem_step;
               cur_blk_in  = seq_ff[SEQ_W-1:3];
               stop_blk_in = (verdict_ff == V_GAP) ? exp_ff[SEQ_W-1:3] : seq_ff[SEQ_W-1:3];
               cur_act_in  = 1'b1;
               fill_idx_in = '0;
               state_in    = (verdict_ff == V_JUMP) ? ST_FILL : ST_WALK;
            end
         end
         ST_FILL: begin
            wr_en       = 1'b1;
            wr_idx      = fill_idx_ff;
            wr_data     = (fill_idx_ff == rem_ff) ? ~seq_bit : BYTE_ONES;
            fill_idx_in = fill_idx_ff + WIN_W'(1);
            cur_act_in  = 1'b0;
            if (fill_idx_ff == w_ff - WIN_W'(1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_WALK: begin
            // walk backward from the packet's byte; a write from the previous cycle is forwarded
            if (cur_act_ff) begin
               rd_en      = 1'b1;
               p1_vld_in  = 1'b1;
               p1_idx_in  = cur_idx_ff;
               p1_set_in  = (verdict_ff == V_GAP) ? (lo_mask & hi_mask) : '0;
               p1_clr_in  = is_top ? seq_bit : '0;
               p1_last_in = (cur_blk_ff == stop_blk_ff);
               cur_act_in = (cur_blk_ff != stop_blk_ff);
               cur_blk_in = cur_blk_ff - BLK_W'(1);
               cur_idx_in = (cur_idx_ff == '0) ? w_ff - WIN_W'(1) : cur_idx_ff - WIN_W'(1);
            end
            if (p1_vld_ff) begin
               if (verdict_ff == V_LATE_FILLED && (base & p1_clr_ff) == '0) begin
                  verdict_in = V_REPLAY;
                  accept_in  = 1'b0;
                  state_in   = ST_FINISH;
               end else begin
                  wr_en = 1'b1;
                  if (p1_last_ff) begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_accepted_in = accept_ff;
               rsp_verdict_in  = verdict_ff;
               rsp_lost_in     = (verdict_ff == V_JUMP) ? diff_ff : '0;
               rsp_total_in    = accept_ff ? cnt_next : cnt_ff;
               if (accept_ff) begin
                  exp_in = exp_next;
                  cnt_in = cnt_next;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      fwd_vld_in  = wr_en;
      fwd_idx_in  = wr_idx;
      fwd_data_in = wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         window_bytes_ff <= WIN_RESET;
         exp_ff          <= '0;
         cnt_ff          <= '0;
         cur_act_ff      <= 1'b0;
         p1_vld_ff       <= 1'b0;
         fwd_vld_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         window_bytes_ff <= window_bytes_in;
         exp_ff          <= exp_in;
         cnt_ff          <= cnt_in;
         cur_act_ff      <= cur_act_in;
         p1_vld_ff       <= p1_vld_in;
         fwd_vld_ff      <= fwd_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff          <= seq_in;
      seq_inc_ff      <= seq_inc_in;
      diff_ff         <= diff_in;
      exp_plus_ff     <= exp_plus_in;
      exp_minus_ff    <= exp_minus_in;
      ge_ff           <= ge_in;
      w_ff            <= w_in;
      verdict_ff      <= verdict_in;
      accept_ff       <= accept_in;
      div_ff          <= div_in;
      rem_ff          <= rem_in;
      mcnt_ff         <= mcnt_in;
      cur_idx_ff      <= cur_idx_in;
      cur_blk_ff      <= cur_blk_in;
      stop_blk_ff     <= stop_blk_in;
      fill_idx_ff     <= fill_idx_in;
      p1_idx_ff       <= p1_idx_in;
      p1_set_ff       <= p1_set_in;
      p1_clr_ff       <= p1_clr_in;
      p1_last_ff      <= p1_last_in;
      fwd_idx_ff      <= fwd_idx_in;
      fwd_data_ff     <= fwd_data_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_verdict_ff  <= rsp_verdict_in;
      rsp_lost_ff     <= rsp_lost_in;
      rsp_total_ff    <= rsp_total_in;
   end

   // late bitmap RAM, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         late_mem[AW'(wr_idx)] <= wr_data;
      end
      if (rd_en) begin
         mem_rd_data_ff  <= late_mem[AW'(rd_idx)];
         mem_rd_valid_ff <= late_vld_ff[AW'(rd_idx)];
      end
   end

   // an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         late_vld_ff <= '0;
      end else if (wr_en) begin
         late_vld_ff[AW'(wr_idx)] <= 1'b1;
      end
   end

endmodule

// ----- sim/tb_anti_replay_window_top.sv -----
module tb_anti_replay_window_top;
   timeunit 1ns;
   timeprecision 1ps;
   import arw_pkg::*;

   localparam int MAP_BYTES   = 32;
   localparam int PHASE_ITEMS = 95;
   localparam int QUIET_LIMIT = 2000;

   typedef struct packed {
      logic [SEQ_W-1:0] seq;
      logic             accepted;
      arw_verdict_type  verdict;
      logic [SEQ_W-1:0] lost_count;
      logic [SEQ_W-1:0] received_total;
   } verdict_rec_type;

   logic clock;
   logic reset;

   arw_req_if req_ch();
   arw_rsp_if rsp_ch();
   arw_csr_if csr_ch();

   anti_replay_window_top #(.MAX_WINDOW_BYTES(MAP_BYTES)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // filter state as seen by the scoreboard
   logic [WIN_W-1:0]  win_cfg;
   logic [SEQ_W-1:0]  next_seq;
   logic [BYTE_W-1:0] late_map [MAP_BYTES];
   logic [SEQ_W-1:0]  pkt_count;

   logic [SEQ_W-1:0] seq_backlog [$];
   verdict_rec_type  verdict_q [$];

   int unsigned items_queued = 0;
   int unsigned items_taken  = 0;
   int unsigned fail_count   = 0;
   int unsigned quiet_cycles = 0;
   logic        req_took     = 1'b0;
   logic        steady       = 1'b0;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned map_slot(logic [SEQ_W-1:0] n, int unsigned win);
      return (n >> 3) % win;
   endfunction

   function automatic verdict_rec_type screen_datagram(logic [SEQ_W-1:0] seq);
      verdict_rec_type  r;
      int unsigned      win;
      int unsigned      b;
      logic [SEQ_W-1:0] span;
      logic [SEQ_W-1:0] far_mark;
      logic [SEQ_W-1:0] gap_len;
      logic [SEQ_W-1:0] k;
      logic [SEQ_W-1:0] n;
      logic             too_old;
      win      = (win_cfg > MAP_BYTES) ? MAP_BYTES : win_cfg;
      span     = win * 8;
      far_mark = next_seq + span;
      r.seq            = seq;
      r.accepted       = 1'b1;
      r.verdict        = V_IN_ORDER;
      r.lost_count     = '0;
      r.received_total = '0;
      if (win != 0) begin
         if (seq != next_seq) begin
            if (seq >= far_mark) begin
               for (b = 0; b < win; b++) late_map[b] = BYTE_ONES;
               r.lost_count = seq - next_seq;
               r.verdict    = V_JUMP;
            end else if (seq < next_seq) begin
               too_old = (next_seq >= span) && (seq < next_seq - span);
               if (too_old || !late_map[map_slot(seq, win)][seq[2:0]]) begin
                  // dropped: state untouched
                  r.accepted       = 1'b0;
                  r.verdict        = too_old ? V_TOO_OLD : V_REPLAY;
                  r.received_total = pkt_count;
                  return r;
               end
               r.verdict = V_LATE_FILLED;
            end else begin
               n       = next_seq;
               gap_len = seq - next_seq;
               for (k = 0; k < gap_len; k++) begin
                  late_map[map_slot(n, win)][n[2:0]] = 1'b1;
                  n++;
               end
               r.verdict = V_GAP;
            end
         end
         late_map[map_slot(seq, win)][seq[2:0]] = 1'b0;
      end
      if (seq >= next_seq) next_seq = seq + 1;
      pkt_count        = (next_seq == 0) ? '0 : pkt_count + 1;
      r.received_total = pkt_count;
      return r;
   endfunction

   // request driver and response back-pressure
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (!req_ch.valid || req_took) begin
            if (seq_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 29)) begin
               req_ch.valid      <= 1'b1;
               req_ch.seq_number <= seq_backlog.pop_front();
            end else begin
               req_ch.valid      <= 1'b0;
               req_ch.seq_number <= $urandom;
            end
         end
         rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 29);
      end
   end

   // monitor: config tracking, response check, prediction on accept
   always @(posedge clock) begin
      verdict_rec_type want;
      if (reset) begin
         win_cfg   = WIN_RESET;
         next_seq  = '0;
         pkt_count = '0;
         foreach (late_map[i]) late_map[i] = '0;
         req_took     <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) win_cfg = csr_ch.window_bytes;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (verdict_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected response verdict %0d total %0d", $time,
                           rsp_ch.verdict, rsp_ch.received_total);
            end else begin
               want = verdict_q.pop_front();
               if (rsp_ch.accepted !== want.accepted || rsp_ch.verdict !== want.verdict ||
                   rsp_ch.lost_count !== want.lost_count ||
                   rsp_ch.received_total !== want.received_total) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $write("%0t: seq %h exp acc %0d verdict %0d lost %h total %h,",
                            $time, want.seq, want.accepted, want.verdict,
                            want.lost_count, want.received_total);
                     $display(" got acc %0d verdict %0d lost %h total %h",
                              rsp_ch.accepted, rsp_ch.verdict, rsp_ch.lost_count,
                              rsp_ch.received_total);
                  end
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            verdict_q.push_back(screen_datagram(req_ch.seq_number));
            items_taken++;
         end
         req_took <= req_ch.valid && req_ch.ready;
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_seq(input logic [SEQ_W-1:0] s);
      seq_backlog.push_back(s);
      items_queued++;
   endtask

   task automatic write_window(input logic [WIN_W-1:0] w);
      @(negedge clock);
      csr_ch.valid        <= 1'b1;
      csr_ch.window_bytes <= w;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (items_taken != items_queued || verdict_q.size() != 0);
   endtask

   // mostly well-formed traffic around the running expected number
   task automatic fill_random(input logic [WIN_W-1:0] w, input int n);
      int unsigned      span;
      int unsigned      pick;
      logic [SEQ_W-1:0] cursor;
      logic [SEQ_W-1:0] seq;
      span   = ((w > MAP_BYTES) ? MAP_BYTES : w) * 8;
      @(posedge clock);
      cursor = next_seq;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 30)      seq = cursor;
         else if (pick < 50) seq = cursor + $urandom_range(1, (span > 1) ? span - 1 : 300);
         else if (pick < 70) seq = cursor - $urandom_range(1, (span != 0) ? span : 300);
         else if (pick < 78) seq = cursor - span - $urandom_range(1, 1000);
         else if (pick < 85) seq = cursor + span + $urandom_range(0, 5000);
         else if (pick < 90) seq = 32'hFFFF_FFFF - $urandom_range(0, 300);
         else                seq = $urandom;
         if (seq >= cursor) cursor = seq + 1;
         queue_seq(seq);
      end
   endtask

   // watchdog
   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      logic [SEQ_W-1:0] opening [19] = '{
         32'd0, 32'd1, 32'd2, 32'd10, 32'd5, 32'd5, 32'd11, 32'd1000, 32'd700,
         32'd800, 32'd800, 32'd1001, 32'd1100, 32'd1050, 32'd1356,
         32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
      logic [SEQ_W-1:0] open_window [5] = '{32'd5, 32'd5, 32'd3, 32'hFFFF_FFFF, 32'd7};
      logic [WIN_W-1:0] win_plan [10] = '{6'd32, 6'd1, 6'd63, 6'd0, 6'd8, 6'd32,
                                          6'd33, 6'd2, 6'd20, 6'd0};
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.seq_number   = '0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.window_bytes = '0;
      win_plan[9]         = WIN_W'($urandom_range(0, 63));
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // in order, gap, late fill, replay, too old, far jump, full gap, wrap
      write_window(6'd32);
      @(posedge clock);
      foreach (opening[i]) queue_seq(opening[i]);
      wait_drained();

      // checking disabled
      write_window(6'd0);
      @(posedge clock);
      foreach (open_window[i]) queue_seq(open_window[i]);
      wait_drained();

      foreach (win_plan[p]) begin
         write_window(win_plan[p]);
         steady = (p == 5);
         fill_random(win_plan[p], PHASE_ITEMS);
         wait_drained();
      end
      steady = 1'b0;

      repeat (40) @(posedge clock);
      if (fail_count == 0 && verdict_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
